// ===== sv/bmpx_pkg.sv =====
package bmpx_pkg;

  localparam int MAX_MAGIC_CHARS = 4;

  localparam int BYTE_W   = 8;
  localparam int WORD_W   = 32;
  localparam int HDR_W    = 10;
  localparam int MLEN_W   = 3;
  localparam int KIND_W   = 3;
  localparam int CFG_IDX_W = 2;

  typedef enum logic [KIND_W-1:0] {
    KIND_EXT_CHAR = 3'd0,
    KIND_PAYLOAD  = 3'd1,
    KIND_MISMATCH = 3'd2,
    KIND_EXT_LEN  = 3'd3,
    KIND_PAY_LEN  = 3'd4
  } bmpx_kind_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HEADER_BYTES = 2'd0,
    CFG_MAGIC_WORD   = 2'd1,
    CFG_MAGIC_LENGTH = 2'd2
  } bmpx_cfg_idx_e;

  // One queued request: only the hidden bit and the restart flag matter downstream.
  typedef struct packed {
    logic lsb;
    logic restart;
  } bmpx_item_t;

  typedef struct packed {
    logic       valid;
    bmpx_item_t item;
  } bmpx_q_t;

  typedef struct packed {
    logic [HDR_W-1:0]  header_bytes;
    logic [WORD_W-1:0] magic_word;
    logic [MLEN_W-1:0] magic_length;
  } bmpx_cfg_t;

endpackage

// ===== sv/bmpx_if.sv =====
interface bmpx_in_if;
  logic                        valid;
  logic                        ready;
  logic [bmpx_pkg::BYTE_W-1:0] image_byte;
  logic                        restart;

  modport source (output valid, output image_byte, output restart, input ready);
  modport sink (input valid, input image_byte, input restart, output ready);
endinterface

interface bmpx_out_if;
  logic                        valid;
  logic                        ready;
  logic [bmpx_pkg::KIND_W-1:0] result_kind;
  logic [bmpx_pkg::WORD_W-1:0] result_value;
  logic                        result_last;

  modport source (output valid, output result_kind, output result_value,
                  output result_last, input ready);
  modport sink (input valid, input result_kind, input result_value,
                input result_last, output ready);
endinterface

interface bmpx_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [bmpx_pkg::CFG_IDX_W-1:0] index;
  logic [bmpx_pkg::WORD_W-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== sv/bmpx_front.sv =====
module bmpx_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  bmpx_in_if.sink        in_i,
  input  logic           pop_i,
  output bmpx_pkg::bmpx_q_t q_o
);
  import bmpx_pkg::*;

  bmpx_item_t mem_q [2];
  logic       wr_ptr_q;
  logic       rd_ptr_q;
  logic [1:0] count_q;
  logic [1:0] count_d;
  logic       push;

  assign in_i.ready = (count_q != 2'd2);
  assign push       = in_i.valid && in_i.ready;

  assign q_o.valid = (count_q != 2'd0);
  assign q_o.item  = mem_q[rd_ptr_q];

  always_comb begin
    count_d = count_q;
    if (push && !pop_i) begin
      count_d = count_q + 2'd1;
    end else if (!push && pop_i) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      count_q <= count_d;
      if (push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= '{lsb: in_i.image_byte[0], restart: in_i.restart};
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= 2'd2)
    else $error("queue count out of range");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> count_q != 2'd0)
    else $error("pop from an empty queue");

  a_ptr_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == 2'd0 || count_q == 2'd2) |-> wr_ptr_q == rd_ptr_q)
    else $error("queue pointers disagree with count");

endmodule

// ===== sv/bmpx_back.sv =====
module bmpx_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  bmpx_pkg::bmpx_cfg_t cfg_i,
  input  bmpx_pkg::bmpx_q_t   q_i,
  output logic                pop_o,
  bmpx_out_if.source          out_o
);
  import bmpx_pkg::*;

  typedef enum logic [2:0] {
    PH_HEADER  = 3'd0,
    PH_MAGIC   = 3'd1,
    PH_EXTLEN  = 3'd2,
    PH_EXTCHR  = 3'd3,
    PH_PAYLEN  = 3'd4,
    PH_PAYLOAD = 3'd5,
    PH_DONE    = 3'd6
  } phase_e;

  phase_e            phase_q, phase_d;
  logic [HDR_W-1:0]  header_count_q, header_count_d;
  logic [4:0]        bit_count_q, bit_count_d;
  logic [WORD_W-1:0] bit_shift_q, bit_shift_d;
  logic [2:0]        magic_index_q, magic_index_d;
  logic [WORD_W-1:0] remaining_q, remaining_d;

  logic              out_valid_q;
  bmpx_kind_e        out_kind_q;
  logic [WORD_W-1:0] out_value_q;
  logic              out_last_q;

  logic              res_valid;
  bmpx_kind_e        res_kind;
  logic [WORD_W-1:0] res_value;
  logic              res_last;

  logic              fire;
  logic [3:0]        magic_n;
  logic [3:0]        pos_w;
  logic [2:0]        pos;
  logic [2*WORD_W-1:0] magic_ext;
  logic [BYTE_W-1:0] want;
  logic              go;
  logic              need8;
  logic              word_done;
  logic [WORD_W-1:0] val;

  // Characters past the configured word compare against zero.
  assign magic_ext = {{WORD_W{1'b0}}, cfg_i.magic_word};
  assign magic_n   = ({1'b0, cfg_i.magic_length} > 4'(MAX_MAGIC_CHARS)) ?
                     4'(MAX_MAGIC_CHARS) : {1'b0, cfg_i.magic_length};

  assign fire  = q_i.valid && (!out_valid_q || out_o.ready);
  assign pop_o = fire;

  always_comb begin
    phase_d        = phase_q;
    header_count_d = header_count_q;
    bit_count_d    = bit_count_q;
    bit_shift_d    = bit_shift_q;
    magic_index_d  = magic_index_q;
    remaining_d    = remaining_q;
    res_valid      = 1'b0;
    res_kind       = KIND_EXT_CHAR;
    res_value      = '0;
    res_last       = 1'b0;
    go             = 1'b1;
    need8          = 1'b0;
    word_done      = 1'b0;
    val            = '0;
    pos_w          = '0;
    pos            = '0;
    want           = '0;

    if (q_i.item.restart) begin
      phase_d        = PH_HEADER;
      header_count_d = '0;
      bit_count_d    = '0;
      bit_shift_d    = '0;
      magic_index_d  = '0;
      remaining_d    = '0;
    end

    if (phase_d == PH_HEADER) begin
      if (header_count_d < cfg_i.header_bytes) begin
        header_count_d = header_count_d + 10'd1;
        go = 1'b0;
      end else begin
        phase_d       = (magic_n != 4'd0) ? PH_MAGIC : PH_EXTLEN;
        magic_index_d = '0;
        bit_count_d   = '0;
        bit_shift_d   = '0;
      end
    end

    if (go && phase_d != PH_DONE) begin
      bit_shift_d = {bit_shift_d[WORD_W-2:0], q_i.item.lsb};
      bit_count_d = bit_count_d + 5'd1;
      need8       = !(phase_d == PH_EXTLEN || phase_d == PH_PAYLEN);
      // A length word completes when the five-bit count wraps around.
      word_done   = need8 ? (bit_count_d == 5'd8) : (bit_count_d == 5'd0);
      if (word_done) begin
        bit_count_d = '0;
        val         = need8 ? {24'd0, bit_shift_d[BYTE_W-1:0]} : bit_shift_d;
        bit_shift_d = '0;
        case (phase_d)
          PH_MAGIC: begin
            pos_w = magic_n - 4'd1 - {1'b0, magic_index_d};
            pos   = pos_w[2:0];
            want  = magic_ext[{pos, 3'b000} +: BYTE_W];
            if (({1'b0, magic_index_d} >= magic_n) || (val[BYTE_W-1:0] != want)) begin
              phase_d   = PH_DONE;
              res_valid = 1'b1;
              res_kind  = KIND_MISMATCH;
              res_last  = 1'b1;
            end else begin
              magic_index_d = magic_index_d + 3'd1;
              if ({1'b0, magic_index_d} >= magic_n) begin
                phase_d = PH_EXTLEN;
              end
            end
          end
          PH_EXTLEN: begin
            remaining_d = val;
            phase_d     = (val != '0) ? PH_EXTCHR : PH_PAYLEN;
            res_valid   = 1'b1;
            res_kind    = KIND_EXT_LEN;
            res_value   = val;
          end
          PH_EXTCHR: begin
            if (remaining_d == 32'd1) begin
              phase_d = PH_PAYLEN;
            end
            remaining_d = remaining_d - 32'd1;
            res_valid   = 1'b1;
            res_kind    = KIND_EXT_CHAR;
            res_value   = val;
          end
          PH_PAYLEN: begin
            remaining_d = val;
            phase_d     = (val != '0) ? PH_PAYLOAD : PH_DONE;
            res_valid   = 1'b1;
            res_kind    = KIND_PAY_LEN;
            res_value   = val;
            res_last    = (val == '0);
          end
          PH_PAYLOAD: begin
            res_last    = (remaining_d == 32'd1);
            if (remaining_d == 32'd1) begin
              phase_d = PH_DONE;
            end
            remaining_d = remaining_d - 32'd1;
            res_valid   = 1'b1;
            res_kind    = KIND_PAYLOAD;
            res_value   = val;
          end
          default: begin
            phase_d = PH_DONE;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q        <= PH_HEADER;
      header_count_q <= '0;
      bit_count_q    <= '0;
      bit_shift_q    <= '0;
      magic_index_q  <= '0;
      remaining_q    <= '0;
      out_valid_q    <= 1'b0;
    end else begin
      if (fire) begin
        phase_q        <= phase_d;
        header_count_q <= header_count_d;
        bit_count_q    <= bit_count_d;
        bit_shift_q    <= bit_shift_d;
        magic_index_q  <= magic_index_d;
        remaining_q    <= remaining_d;
      end
      if (fire && res_valid) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && res_valid) begin
      out_kind_q  <= res_kind;
      out_value_q <= res_value;
      out_last_q  <= res_last;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.result_kind  = out_kind_q;
  assign out_o.result_value = out_value_q;
  assign out_o.result_last  = out_last_q;

  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && res_valid && res_last |=> phase_q == PH_DONE)
    else $error("final result did not end the decode");

  a_done_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && !q_i.item.restart && phase_q == PH_DONE |-> !res_valid)
    else $error("result produced after the decode ended");

  a_char_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_MAGIC || phase_q == PH_EXTCHR || phase_q == PH_PAYLOAD)
      |-> bit_count_q < 5'd8)
    else $error("character bit count overran");

  a_hold_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_o.ready |-> !fire)
    else $error("request consumed while a result was stalled");

endmodule

// ===== sv/bmp_lsb_stego_extractor_core.sv =====
// Pulls hidden data out of the least significant bits of a BMP byte stream. After
// header_bytes skipped bytes, eight bits build a character and thirty-two bits build a
// length, most significant bit first: the magic characters are checked (a mismatch gives
// one result of kind 2 with result_last set), then the extension length, the extension
// characters, the payload length and the payload bytes come out as results. A byte with
// restart set starts a new image. The block takes one image byte per clock cycle while
// results are taken and yields at most one result per byte; a byte passes through a
// two-entry input queue, and its result is registered in a one-entry output register.
// The parser state advances once per byte, so throughput is one byte per cycle as long
// as results are taken. Configuration writes are always accepted and take effect for the
// next byte parsed.
module bmp_lsb_stego_extractor_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  bmpx_in_if.sink     in_i,
  bmpx_out_if.source  out_o,
  bmpx_cfg_if.sink    cfg_i
);
  import bmpx_pkg::*;

  bmpx_cfg_t cfg_q;
  bmpx_q_t   queue;
  logic      pop;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.header_bytes <= 10'd54;
      cfg_q.magic_word   <= '0;
      cfg_q.magic_length <= 3'd2;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        CFG_HEADER_BYTES: cfg_q.header_bytes <= cfg_i.data[HDR_W-1:0];
        CFG_MAGIC_WORD:   cfg_q.magic_word   <= cfg_i.data;
        CFG_MAGIC_LENGTH: cfg_q.magic_length <= cfg_i.data[MLEN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  bmpx_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .pop_i  (pop),
    .q_o    (queue)
  );

  bmpx_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_q),
    .q_i    (queue),
    .pop_o  (pop),
    .out_o  (out_o)
  );

endmodule
